FILE: sv/rbd_pkg.sv
`timescale 1ns / 1ps
// rbd_pkg: shared constants, register codes and per-channel helpers for the
// 2x2 RGBA box downsampler. No dependencies.
package rbd_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int WIDTH_RESET     = 1024;
    localparam int HEIGHT_RESET    = 1024;

    localparam int CFG_W   = 13;
    localparam int HGT_W   = 13;
    localparam int ROW_W   = 12;
    localparam int PIX_W   = 32;
    localparam int CH_W    = 8;
    localparam int FLD_W   = 9;
    localparam int NUM_CH  = 4;
    localparam int PAIR_W  = FLD_W * NUM_CH;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PAIR_W-1:0] t_pair;

    // spread four bytes into four 9-bit fields
    function automatic t_pair spread_pixel(input logic [PIX_W-1:0] p);
        t_pair r;
        r = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            r[c*FLD_W +: FLD_W] = {1'b0, p[c*CH_W +: CH_W]};
        end
        return r;
    endfunction

    function automatic t_pair add_fields(input t_pair a, input t_pair b);
        t_pair r;
        r = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            r[c*FLD_W +: FLD_W] = a[c*FLD_W +: FLD_W] + b[c*FLD_W +: FLD_W];
        end
        return r;
    endfunction

    // sum of two pair fields, divided by 4
    function automatic logic [PIX_W-1:0] avg_block(input t_pair a, input t_pair b);
        logic [PIX_W-1:0]  r;
        logic [FLD_W:0]    s;
        r = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            s = {1'b0, a[c*FLD_W +: FLD_W]} + {1'b0, b[c*FLD_W +: FLD_W]};
            r[c*CH_W +: CH_W] = s[FLD_W:2];
        end
        return r;
    endfunction

endpackage

FILE: sv/rbd_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// rbd_line_store: single-port line memory of horizontal pair sums,
// with a registered read. Uses rbd_pkg.
module rbd_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_addr,
    input  wire rbd_pkg::t_pair       i_wdata,
    output      rbd_pkg::t_pair       o_rdata
);
    import rbd_pkg::*;

    t_pair r_mem [0:DEPTH-1];
    t_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: sv/rgba_box_downsample_2x2.sv
`timescale 1ns / 1ps
`default_nettype none
// rgba_box_downsample_2x2: top level of the 2x2 box-filter mipmap downsampler.
// Uses rbd_pkg and rbd_line_store.
//
//  channel   signals                                   direction
//  in        i_in_valid, o_in_stall, i_in_pixel        pixel requests in, raster order
//  out       o_out_valid, i_out_stall, o_out_pixel,    averaged pixel requests out
//            o_frame_last
//  cfg       i_cfg_we, i_cfg_index, i_cfg_data         register writes, no read-back
//
// One pixel accepted per cycle while o_in_stall is low. After its last pixel,
// a result passes the line store read, then the output register.
// Reset is synchronous: counters, held sum and pipeline valids clear; the
// line store is not cleared (even rows write before odd rows read).
// An output stall backs up through two registers before o_in_stall rises.
module rgba_box_downsample_2x2 #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire logic [rbd_pkg::PIX_W-1:0]     i_in_pixel,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      logic [rbd_pkg::PIX_W-1:0]     o_out_pixel,
    output      logic                          o_frame_last,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [rbd_pkg::CFG_W-1:0]     i_cfg_data
);
    import rbd_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;
    localparam int WIDTH_RST_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [WW-1:0]     r_width;
    logic [HGT_W-1:0]  r_height;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    t_pair             r_held;

    logic [CW-1:0]     n_col;
    logic [ROW_W-1:0]  n_row;
    logic [WW-1:0]     n_width;
    logic [HGT_W-1:0]  n_height;
    logic [CMPW-1:0]   cfg_ext;

    logic              r_s1_valid;
    t_pair             r_s1_pair;
    logic              r_s1_last;
    logic              r_s2_valid;
    logic [PIX_W-1:0]  r_out_pixel;
    logic              r_out_last;

    logic              s2_free;
    logic              s1_free;
    logic              accept;
    t_pair             pix_fields;
    t_pair             pair;
    t_pair             above;
    logic [AW-1:0]     idx;
    logic              col_ok;
    logic              idx_ok;
    logic              row_ok;
    logic              pair_ok;
    logic              mem_we;
    logic              mem_re;
    logic              is_last;
    logic              col_wrap;
    logic              row_wrap;
    logic [WW-1:0]     col_last;
    logic [HGT_W-1:0]  row_last;

    // clamp register values at write time
    always_comb begin
        cfg_ext = CMPW'(i_cfg_data);
        if (cfg_ext == '0) begin
            n_width = WW'(1);
        end else if (cfg_ext > CMPW'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = WW'(cfg_ext);
        end
        if (i_cfg_data == '0) begin
            n_height = HGT_W'(1);
        end else if ({1'b0, i_cfg_data} > (CFG_W + 1)'(HEIGHT_LIMIT)) begin
            n_height = HGT_W'(HEIGHT_LIMIT);
        end else begin
            n_height = HGT_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(WIDTH_RST_EFF);
            r_height <= HGT_W'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_width  <= n_width;
                REG_IMAGE_HEIGHT: r_height <= n_height;
                default: ;
            endcase
        end
    end

    assign s2_free    = !r_s2_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;

    assign pix_fields = spread_pixel(i_in_pixel);
    assign pair       = add_fields(r_held, pix_fields);
    assign idx        = AW'(r_col >> 1);
    assign col_ok     = WW'(r_col) < r_width;
    assign idx_ok     = (r_col >> 1) < CW'(LINE_DEPTH);
    assign row_ok     = {1'b0, (r_row | ROW_W'(1))} < r_height;
    assign pair_ok    = r_col[0] && col_ok && idx_ok && row_ok;
    assign mem_we     = accept && pair_ok && !r_row[0];
    assign mem_re     = accept && pair_ok && r_row[0];

    assign col_last   = {r_width[WW-1:1], 1'b0} - WW'(1);
    assign row_last   = {r_height[HGT_W-1:1], 1'b0} - HGT_W'(1);
    assign is_last    = (WW'(r_col) == col_last) && ({1'b0, r_row} == row_last);

    assign col_wrap   = ((WW + 1)'(r_col) + (WW + 1)'(1)) >= (WW + 1)'(r_width);
    assign row_wrap   = ({1'b0, r_row} + HGT_W'(1)) >= r_height;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!r_col[0]) begin
                r_held <= pix_fields;
            end
        end
    end

    rbd_line_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (idx),
        .i_wdata (pair),
        .o_rdata (above)
    );

    // stage 1: line read in flight; stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= mem_re;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_s1_pair <= pair;
            r_s1_last <= is_last;
        end
        if (s2_free && r_s1_valid) begin
            r_out_pixel <= avg_block(above, r_s1_pair);
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid  = r_s2_valid;
    assign o_out_pixel  = r_out_pixel;
    assign o_frame_last = r_out_last;

`ifndef ASSERT_OFF
    a_read_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> r_s1_valid)
        else $error("line read did not reach stage 1");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_free) |=> (r_s1_valid && $stable(r_s1_pair)))
        else $error("stage 1 request lost under stall");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && col_wrap) |=> (r_col == '0))
        else $error("column counter failed to wrap");
`endif

endmodule
`default_nettype wire
